// ===== design/sti_pkg.sv =====
// Package for the sorted table insert block: payload structs, status codes,
// and the control and flag structs between the top level and its cells.
// No dependencies.
package sti_pkg;

  localparam int DEPTH = 16;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_APPENDED = 2'd3;

  localparam logic MODE_APPEND = 1'b0;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] position;
    logic [4:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic check;
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic eq;
    logic past;
  } cell_flags_t;

endpackage

// ===== design/sti_cell.sv =====
// One table cell: holds an entry, compares it with the search value when
// checked, and loads the value on a load or its lower neighbor's entry on a shift.
// Depends on sti_pkg.
module sti_cell (
  input  logic               clk,
  input  logic               order_descending,
  input  logic signed [31:0] value,
  input  logic signed [31:0] prev_entry,
  input  sti_pkg::cell_ctrl_t ctrl,
  output logic signed [31:0] entry,
  output sti_pkg::cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= value;
    end else if (ctrl.shift) begin
      entry <= prev_entry;
    end
  end

  always_comb begin
    flags.eq   = ctrl.check && (entry == value);
    flags.past = ctrl.check && (order_descending ? (entry < value) : (entry > value));
  end

endmodule

// ===== design/sorted_table_insert_top.sv =====
// Sorted table insert: a chain of cells holding a sorted table of signed values.
// After a transfer in, the search checks one cell per cycle; the result is registered
// once an equal entry, an entry past the value or the end of the entries is reached
// (at once for append), later while the previous result is stalled. Insert and
// shift act together. A new item is taken the cycle after the result is registered.
// Synchronous reset empties the table and sets ascending order; entries are not cleared.
module sorted_table_insert_top #(
  parameter int DEPTH = sti_pkg::DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sti_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sti_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state;
  logic                 order_descending;
  sti_pkg::in_item_t    item;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   scan_idx;

  logic signed [31:0]   entry_q [DEPTH];
  sti_pkg::cell_flags_t flags   [DEPTH];
  sti_pkg::cell_ctrl_t  ctrl    [DEPTH];

  logic                 any_eq;
  logic                 any_past;
  logic                 is_full;
  logic                 decide;
  logic [1:0]           status;
  logic [COUNT_W-1:0]   pos;
  logic                 out_free;
  logic                 commit;
  logic                 wr;
  logic [COUNT_W-1:0]   count_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign is_full   = (count == COUNT_W'(DEPTH));

  always_comb begin
    any_eq   = 1'b0;
    any_past = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_eq   = any_eq   | flags[i].eq;
      any_past = any_past | flags[i].past;
    end
  end

  always_comb begin
    decide = 1'b0;
    status = sti_pkg::ST_INSERTED;
    pos    = count;
    if (item.mode == sti_pkg::MODE_APPEND) begin
      decide = 1'b1;
      status = is_full ? sti_pkg::ST_FULL : sti_pkg::ST_APPENDED;
    end else if (scan_idx == count) begin
      decide = 1'b1;
      status = is_full ? sti_pkg::ST_FULL : sti_pkg::ST_INSERTED;
    end else if (any_eq) begin
      decide = 1'b1;
      status = sti_pkg::ST_FOUND;
      pos    = scan_idx;
    end else if (any_past) begin
      decide = 1'b1;
      status = is_full ? sti_pkg::ST_FULL : sti_pkg::ST_INSERTED;
      pos    = scan_idx;
    end
  end

  assign commit     = (state == S_SCAN) && decide && out_free;
  assign wr         = commit && (status == sti_pkg::ST_INSERTED ||
                                 status == sti_pkg::ST_APPENDED);
  assign count_next = count + COUNT_W'(wr);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctrl[i].check = (state == S_SCAN) && (scan_idx == COUNT_W'(i));
      ctrl[i].load  = wr && (pos == COUNT_W'(i));
      ctrl[i].shift = wr && (COUNT_W'(i) > pos) && (COUNT_W'(i) <= count);
    end

    if (i == 0) begin : g_head
      sti_cell u_cell (
        .clk              (clk),
        .order_descending (order_descending),
        .value            (item.value),
        .prev_entry       (item.value),
        .ctrl             (ctrl[i]),
        .entry            (entry_q[i]),
        .flags            (flags[i])
      );
    end else begin : g_body
      sti_cell u_cell (
        .clk              (clk),
        .order_descending (order_descending),
        .value            (item.value),
        .prev_entry       (entry_q[i-1]),
        .ctrl             (ctrl[i]),
        .entry            (entry_q[i]),
        .flags            (flags[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      order_descending <= 1'b0;
      count            <= '0;
      scan_idx         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_descending <= cfg_data;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SCAN;
            scan_idx <= '0;
          end
        end
        S_SCAN: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end else if (!decide) begin
            scan_idx <= scan_idx + COUNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    if (commit) begin
      out_data.status      <= status;
      out_data.position    <= 5'(32'(pos));
      out_data.entry_count <= 5'(32'(count_next));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after input transfer");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    wr |=> count == $past(count) + COUNT_W'(1))
    else $error("table write did not advance entry count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= count)
    else $error("scan ran past valid entries");

endmodule

// ===== verif/sorted_table_insert_top_test.sv =====
// Testbench for sorted_table_insert_top: directed, back-pressure and random tests
// against a table predictor kept in step with every accepted transfer.
// Depends on sti_pkg and the sorted_table_insert_top RTL.
module sorted_table_insert_top_test;

  localparam logic MODE_SEARCH = 1'b1;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * sti_pkg::DEPTH + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sti_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sti_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  logic signed [31:0] tbl [sti_pkg::DEPTH];
  int tbl_count = 0;
  bit order_desc = 1'b0;
  sti_pkg::out_item_t pending_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold = 1'b0;
  int rx_wait = 0;

  sorted_table_insert_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic sti_pkg::out_item_t table_update(sti_pkg::in_item_t item);
    sti_pkg::out_item_t res;
    logic signed [31:0] v;
    int slot;
    int i;
    bit done;
    v = item.value;
    slot = tbl_count;
    done = 1'b0;
    res.entry_count = 5'(tbl_count);
    if (item.mode == sti_pkg::MODE_APPEND) begin
      res.position = 5'(tbl_count);
      if (tbl_count >= sti_pkg::DEPTH) begin
        res.status = sti_pkg::ST_FULL;
      end else begin
        tbl[tbl_count] = v;
        tbl_count++;
        res.status = sti_pkg::ST_APPENDED;
        res.entry_count = 5'(tbl_count);
      end
      return res;
    end
    i = 0;
    while (!done && i < tbl_count) begin
      if (tbl[i] == v) begin
        res.status = sti_pkg::ST_FOUND;
        res.position = 5'(i);
        return res;
      end else if (order_desc ? (tbl[i] < v) : (tbl[i] > v)) begin
        slot = i;
        done = 1'b1;
      end else begin
        i++;
      end
    end
    res.position = 5'(slot);
    if (tbl_count >= sti_pkg::DEPTH) begin
      res.status = sti_pkg::ST_FULL;
      return res;
    end
    for (int j = tbl_count; j > slot; j--) tbl[j] = tbl[j - 1];
    tbl[slot] = v;
    tbl_count++;
    res.status = sti_pkg::ST_INSERTED;
    res.entry_count = 5'(tbl_count);
    return res;
  endfunction

  always @(posedge clk) begin
    sti_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d position %0d count %0d",
                   $time, out_data.status, out_data.position, out_data.entry_count);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_data.status);
            mismatch_count++;
          end
          if (out_data.position !== want.position) begin
            $display("%0t: position expected %0d, got %0d", $time, want.position,
                     out_data.position);
            mismatch_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                     out_data.entry_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(table_update(in_data));
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_wait = rx_idle_on ? $urandom_range(0, 10) : 0;
      else if (rx_wait > 0) rx_wait--;
      out_stall <= rx_hold || (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic mode, input logic signed [31:0] value);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.mode <= mode;
    in_data.value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_sort_order(input bit desc);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= desc;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_desc = desc;
  endtask

  function automatic logic signed [31:0] pick_value();
    int k;
    k = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    case ($urandom_range(0, 5))
      0, 1: return (tbl_count > 0) ? tbl[k] : $urandom();
      2: return (tbl_count > 0) ? tbl[k] + ($urandom_range(0, 1) ? 1 : -1) : $urandom();
      3: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_item(MODE_SEARCH, 32'sd0);
    send_item(MODE_SEARCH, 32'sd0);
    send_item(MODE_SEARCH, VAL_MIN);
    send_item(MODE_SEARCH, VAL_MAX);
    send_item(MODE_SEARCH, 32'sd100);
    send_item(MODE_SEARCH, -32'sd1);
    send_item(MODE_SEARCH, VAL_MAX);
    send_item(MODE_SEARCH, VAL_MIN);
    // load out of order, then search the unsorted table
    send_item(sti_pkg::MODE_APPEND, 32'sd7);
    send_item(MODE_SEARCH, 32'sd50);
    set_sort_order(1'b1);
    send_item(MODE_SEARCH, 32'sd200);
    send_item(MODE_SEARCH, -32'sd5);
    send_item(MODE_SEARCH, 32'sh8000_0001);
    send_item(sti_pkg::MODE_APPEND, 32'sh5555_5555);
    send_item(sti_pkg::MODE_APPEND, 32'shAAAA_AAAA);
    send_item(sti_pkg::MODE_APPEND, -32'sd100);
    send_item(sti_pkg::MODE_APPEND, 32'sd1000);
    send_item(sti_pkg::MODE_APPEND, 32'sd3);
    send_item(sti_pkg::MODE_APPEND, 32'sd3);
    // table is full from here on
    send_item(sti_pkg::MODE_APPEND, 32'sd9);
    send_item(MODE_SEARCH, -32'sd100);
    send_item(MODE_SEARCH, 32'sd12345);
    set_sort_order(1'b0);
    send_item(MODE_SEARCH, 32'sd60);
    send_item(MODE_SEARCH, 32'sd3);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (120) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (12) send_item(1'($urandom_range(0, 1)), pick_value());
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    for (int n = 0; n < 450; n++) begin
      if (n % 50 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end
      if (n % 75 == 74) set_sort_order(1'($urandom_range(0, 1)));
      send_item(($urandom_range(0, 3) == 0) ? sti_pkg::MODE_APPEND : MODE_SEARCH,
                pick_value());
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
